FILE: src/rme_pkg.sv
// Package for the rotation matrix to Euler angle block.
// Holds CORDIC constants, fixed widths and shared types; no dependencies.
`default_nettype none
package rme_pkg;
    localparam int unsigned CordicSteps = 16;
    localparam int unsigned CordicWidth = 24;
    localparam logic signed [CordicWidth-1:0] Pi16 = 24'sd205887;
    localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;
    localparam logic signed [15:0] AngleMax = 16'sd25736;

    // Register stages of the square root and of one CORDIC unit.
    localparam int unsigned SqrtLat = 7;
    localparam int unsigned CordLat = CordicSteps + 1;
    // Stages ahead of the output register: input, square, root, CORDIC.
    localparam int unsigned PipeLat = 2 + SqrtLat + CordLat;

    localparam logic [1:0] PoleNone  = 2'd0;
    localparam logic [1:0] PoleNorth = 2'd1;
    localparam logic [1:0] PoleSouth = 2'd2;

    localparam logic [3:0] CfgHandedness = 4'd0;
    localparam logic [3:0] CfgThreshold  = 4'd1;

    typedef logic signed [CordicWidth-1:0] t_cw;

    typedef struct packed {
        logic signed [15:0] m11;
        logic signed [15:0] m13;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
        logic signed [15:0] m23;
        logic signed [15:0] m31;
        logic signed [15:0] m33;
    } t_matrix;

    typedef struct packed {
        logic signed [15:0] angle_first;
        logic signed [15:0] angle_second;
        logic signed [15:0] angle_third;
        logic [1:0]         pole_case;
    } t_angles;

    function automatic t_cw atan_tab(input logic [3:0] i);
        case (i)
            4'd0:  atan_tab = 24'sd51472;
            4'd1:  atan_tab = 24'sd30386;
            4'd2:  atan_tab = 24'sd16055;
            4'd3:  atan_tab = 24'sd8150;
            4'd4:  atan_tab = 24'sd4091;
            4'd5:  atan_tab = 24'sd2047;
            4'd6:  atan_tab = 24'sd1024;
            4'd7:  atan_tab = 24'sd512;
            4'd8:  atan_tab = 24'sd256;
            4'd9:  atan_tab = 24'sd128;
            4'd10: atan_tab = 24'sd64;
            4'd11: atan_tab = 24'sd32;
            4'd12: atan_tab = 24'sd16;
            4'd13: atan_tab = 24'sd8;
            4'd14: atan_tab = 24'sd4;
            default: atan_tab = 24'sd2;
        endcase
    endfunction
endpackage
`default_nettype wire

FILE: src/rme_stream_if.sv
// Valid/ready stream interface carrying one payload type.
// Depends on nothing; the payload type is a parameter.
`default_nettype none
interface rme_stream_if #(parameter type T = logic) (input wire logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/rme_sqrt.sv
// Pipelined integer square root, one root bit per compare-and-subtract step.
// Depends on rme_pkg for the stage count.
`default_nettype none
module rme_sqrt
    import rme_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [28:0] i_v,
    output logic [14:0]      o_root
);
    // Fifteen steps over seven register stages: four in the first stage,
    // two in each middle stage, one in the last.
    logic [28:0] r_v   [1:SqrtLat];
    logic [28:0] r_res [1:SqrtLat];
    logic [28:0] n_v   [1:SqrtLat];
    logic [28:0] n_res [1:SqrtLat];

    function automatic logic [57:0] sqrt_iter(input logic [28:0] v_in,
                                              input logic [28:0] res_in,
                                              input int idx);
        logic [28:0] v, res, b;
        v = v_in;
        res = res_in;
        b = 29'd1 << (28 - 2 * idx);
        if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
        end else begin
            res = res >> 1;
        end
        return {v, res};
    endfunction

    always_comb begin
        logic [57:0] st;
        st = {i_v, 29'd0};
        for (int k = 0; k < 4; k++) st = sqrt_iter(st[57:29], st[28:0], k);
        n_v[1] = st[57:29];
        n_res[1] = st[28:0];
        for (int j = 2; j <= SqrtLat; j++) begin
            st = {r_v[j-1], r_res[j-1]};
            st = sqrt_iter(st[57:29], st[28:0], 2 * j);
            if (j < SqrtLat) st = sqrt_iter(st[57:29], st[28:0], 2 * j + 1);
            n_v[j] = st[57:29];
            n_res[j] = st[28:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 1; j <= SqrtLat; j++) begin
                r_v[j] <= n_v[j];
                r_res[j] <= n_res[j];
            end
        end
    end
    assign o_root = r_res[SqrtLat][14:0];
endmodule
`default_nettype wire

FILE: src/rme_cordic.sv
// Pipelined CORDIC vectoring atan2, one iteration per register stage.
// Depends on rme_pkg for the arctangent table and widths.
`default_nettype none
module rme_cordic
    import rme_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [16:0] i_y,
    input  wire logic signed [16:0] i_x,
    output logic signed [15:0]      o_angle
);
    t_cw r_x [0:CordicSteps];
    t_cw r_y [0:CordicSteps];
    t_cw r_z [0:CordicSteps];
    logic r_zero [0:CordicSteps];

    // Pre-rotation: scale by 4 and fold the left half plane.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            t_cw x4, y4;
            x4 = t_cw'(i_x) <<< 2;
            y4 = t_cw'(i_y) <<< 2;
            r_zero[0] <= (i_x == 17'sd0) && (i_y == 17'sd0);
            if (x4 < 0) begin
                r_x[0] <= -x4;
                r_y[0] <= -y4;
                r_z[0] <= (y4 >= 0) ? Pi16 : -Pi16;
            end else begin
                r_x[0] <= x4;
                r_y[0] <= y4;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CordicSteps; i++) begin : g_it
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_tab(4'(i));
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_tab(4'(i));
                end
            end
        end
    end

    // Round half up to Q3.13 and saturate; a zero input vector gives angle zero.
    always_comb begin
        t_cw r;
        r = (r_z[CordicSteps] + t_cw'(4)) >>> 3;
        if (r_zero[CordicSteps])          o_angle = '0;
        else if (r > t_cw'(AngleMax))     o_angle = AngleMax;
        else if (r < -t_cw'(AngleMax))    o_angle = -AngleMax;
        else                              o_angle = r[15:0];
    end
endmodule
`default_nettype wire

FILE: src/rotation_matrix_to_euler.sv
// Top level: rotation matrix to Euler angles, fully pipelined.
// Depends on rme_pkg, rme_stream_if, rme_cordic and rme_sqrt.
//
// Usage:
//   s_in carries seven Q1.14 matrix elements; m_out carries three Q3.13
//   angles and a pole flag. A transfer happens when valid and ready are
//   both high at a rising edge of i_clk.
//   Configuration: i_cfg_we with i_cfg_addr 0 (handedness) or 1 (pole
//   threshold) and i_cfg_data; write only while the pipeline is empty.
//   Throughput: one item per cycle unless the output stalls. Path from input
//   transfer to output valid: input and square registers, the square root
//   (7 stages) feeding the pitch CORDIC (17 stages), then the output register.
//   Stall: the whole pipeline advances on one enable; when the output holds
//   a result that is not taken the pipeline freezes, so nothing is lost or
//   repeated. ready is high whenever the output register is empty or drains.
//   Reset (i_rst_n low, synchronous): clear all valid bits and restore
//   handedness 0 and threshold 16351; payload registers are not reset.
`default_nettype none
module rotation_matrix_to_euler
    import rme_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    rme_stream_if.sink       s_in,
    rme_stream_if.source     m_out,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_addr,
    input  wire logic [14:0] i_cfg_data
);
    logic        r_hand;
    logic [14:0] r_thr;
    logic        en;

    // Whole-pipeline enable: advance unless the output holds an untaken result.
    assign en = !m_out.valid || m_out.ready;
    assign s_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hand <= 1'b0;
            r_thr  <= 15'd16351;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CfgHandedness) r_hand <= i_cfg_data[0];
            else if (i_cfg_addr == CfgThreshold) r_thr <= i_cfg_data;
        end
    end

    // Stage 0: register inputs, classify pole, saturate sine.
    t_matrix            r_m;
    logic signed [15:0] r_s;
    logic [1:0]         r_pole0;
    always_ff @(posedge i_clk) begin
        if (en) begin
            logic signed [16:0] thr, m21, s;
            thr = {2'b00, r_thr};
            m21 = 17'(s_in.data.m21);
            r_m <= s_in.data;
            if (m21 > thr)       r_pole0 <= PoleNorth;
            else if (m21 < -thr) r_pole0 <= PoleSouth;
            else                 r_pole0 <= PoleNone;
            s = m21;
            if (s > 17'sd16384)       s = 17'sd16384;
            else if (s < -17'sd16384) s = -17'sd16384;
            r_s <= s[15:0];
        end
    end

    // Stage 1: one minus the square of sine (one 16x16 multiply).
    logic [28:0]        r_sq;
    t_matrix            r_m1;
    logic signed [15:0] r_s1;
    logic [1:0]         r_pole1;
    always_ff @(posedge i_clk) begin
        if (en) begin
            logic signed [31:0] p;
            p = 32'(r_s) * 32'(r_s);
            r_sq <= 29'(29'h1000_0000 - p[28:0]);
            r_m1 <= r_m;
            r_s1 <= r_s;
            r_pole1 <= r_pole0;
        end
    end

    // Square root, 7 register stages; delay the rest alongside it.
    logic [14:0] root;
    rme_sqrt u_sqrt (.i_clk(i_clk), .i_en(en), .i_v(r_sq), .o_root(root));

    t_matrix            r_md [1:SqrtLat];
    logic signed [15:0] r_sd [1:SqrtLat];
    logic [1:0]         r_pd [1:SqrtLat];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_md[1] <= r_m1;
            r_sd[1] <= r_s1;
            r_pd[1] <= r_pole1;
            for (int k = 2; k <= SqrtLat; k++) begin
                r_md[k] <= r_md[k-1];
                r_sd[k] <= r_sd[k-1];
                r_pd[k] <= r_pd[k-1];
            end
        end
    end

    // CORDIC operands; pole case reuses the head unit for atan2(m13,m33).
    t_matrix            md;
    logic signed [16:0] hy, hx, by, bx, py, px;
    logic [1:0]         pd;
    assign md = r_md[SqrtLat];
    assign pd = r_pd[SqrtLat];
    always_comb begin
        if (pd != PoleNone) begin
            hy = 17'(md.m13);
            hx = 17'(md.m33);
        end else begin
            hy = -17'(md.m31);
            hx = 17'(md.m11);
        end
        by = -17'(md.m23);
        bx = 17'(md.m22);
        py = 17'(r_sd[SqrtLat]);
        px = {2'b00, root};
    end

    logic signed [15:0] head, bank, pitch;
    rme_cordic u_head  (.i_clk(i_clk), .i_en(en), .i_y(hy), .i_x(hx), .o_angle(head));
    rme_cordic u_bank  (.i_clk(i_clk), .i_en(en), .i_y(by), .i_x(bx), .o_angle(bank));
    rme_cordic u_pitch (.i_clk(i_clk), .i_en(en), .i_y(py), .i_x(px), .o_angle(pitch));

    logic [1:0] r_pc [1:CordLat];
    logic       r_hc [1:CordLat];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pc[1] <= pd;
            r_hc[1] <= r_hand;
            for (int k = 2; k <= CordLat; k++) begin
                r_pc[k] <= r_pc[k-1];
                r_hc[k] <= r_hc[k-1];
            end
        end
    end

    // Valid bits for every stage up to the output register.
    logic [PipeLat-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en)  r_vld <= {r_vld[PipeLat-2:0], s_in.valid};
    end

    // Output register: select angles by handedness and pole case.
    t_angles r_out;
    logic    r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_vld[PipeLat-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            logic [1:0] p;
            logic signed [15:0] half;
            p = r_pc[CordLat];
            half = (p == PoleNorth) ? HalfPiQ13 : -HalfPiQ13;
            r_out.pole_case <= p;
            if (p != PoleNone) begin
                if (!r_hc[CordLat]) begin
                    r_out.angle_first  <= head;
                    r_out.angle_second <= half;
                    r_out.angle_third  <= '0;
                end else begin
                    r_out.angle_first  <= '0;
                    r_out.angle_second <= head;
                    r_out.angle_third  <= half;
                end
            end else if (!r_hc[CordLat]) begin
                r_out.angle_first  <= head;
                r_out.angle_second <= pitch;
                r_out.angle_third  <= bank;
            end else begin
                r_out.angle_first  <= -bank;
                r_out.angle_second <= head;
                r_out.angle_third  <= pitch;
            end
        end
    end

    assign m_out.valid = r_ov;
    assign m_out.data  = r_out;
endmodule
`default_nettype wire
